[hdl/sfbd_pkg.sv]
// Shared types, widths and fixed coefficients of the spectral flux beat detector.
package sfbd_pkg;

  localparam int unsigned BAND_COUNT_DEF = 16;
  localparam int unsigned BAND_W         = 4;
  localparam int unsigned MAG_W          = 16;
  localparam int unsigned TOTAL_W        = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Stream payload widths; the tdata widths are whole bytes.
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_USER_W = 2;

  // Tracker coefficients; ratios are reduced where that keeps the floor exact.
  localparam int unsigned AVG_DECAY_NUM = 19;   // 95/100
  localparam int unsigned AVG_DECAY_DEN = 20;
  localparam int unsigned FAST_NUM      = 4;    // 8/10
  localparam int unsigned FAST_DEN      = 5;
  localparam int unsigned SLOW_HOLD_NUM = 999;
  localparam int unsigned SLOW_ZERO_NUM = 995;
  localparam int unsigned SLOW_DEN      = 1000;
  localparam int unsigned PEAK_KEEP_NUM = 99;
  localparam int unsigned PEAK_DEN      = 100;
  localparam int unsigned THR_NUM       = 3;    // threshold is 3/8 of the slow maximum
  localparam int unsigned THR_SHIFT     = 3;

  // Numerator widths and reciprocal constants for exact floor division:
  // M = ceil(2^S / d) with S = N + ceil(log2 d) is exact for any N-bit numerator.
  localparam int unsigned AVG_N  = 21;
  localparam int unsigned AVG_S  = 26;
  localparam longint unsigned AVG_M =
    ((64'd1 << AVG_S) + AVG_DECAY_DEN - 1) / AVG_DECAY_DEN;
  localparam int unsigned FAST_N = 18;
  localparam int unsigned FAST_S = 21;
  localparam longint unsigned FAST_M =
    ((64'd1 << FAST_S) + FAST_DEN - 1) / FAST_DEN;
  localparam int unsigned SLOW_N = 26;
  localparam int unsigned SLOW_S = 36;
  localparam longint unsigned SLOW_M =
    ((64'd1 << SLOW_S) + SLOW_DEN - 1) / SLOW_DEN;
  localparam int unsigned PEAK_N = 23;
  localparam int unsigned PEAK_S = 30;
  localparam longint unsigned PEAK_M =
    ((64'd1 << PEAK_S) + PEAK_DEN - 1) / PEAK_DEN;

  // One band's tracker state as it sits in the memory.
  typedef struct packed {
    logic [MAG_W-1:0] prev_mag;
    logic [MAG_W-1:0] prev_flux;
    logic [MAG_W-1:0] avg;
    logic [MAG_W-1:0] fast;
    logic [MAG_W-1:0] slow;
    logic [MAG_W-1:0] peak;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Flux and division operands handed from the read stage to the divide stage.
  typedef struct packed {
    logic              fresh;
    logic              hit;
    logic              fell;
    logic [MAG_W-1:0]  flux;
    logic [MAG_W-1:0]  mag;
    logic              avg_div;
    logic [MAG_W-1:0]  avg_byp;
    logic [AVG_N-1:0]  avg_num;
    logic              fast_div;
    logic [MAG_W-1:0]  fast_byp;
    logic [FAST_N-1:0] fast_num;
    logic              slow_div;
    logic [MAG_W-1:0]  slow_byp;
    logic [SLOW_N-1:0] slow_num;
    logic              peak_div;
    logic [MAG_W-1:0]  peak_byp;
    logic [PEAK_N-1:0] peak_num;
  } num_t;

endpackage

[hdl/sfbd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered, write-first read.
module sfbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // A read of the entry written in the same cycle returns the new data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sfbd_front.sv]
// Read stage arithmetic: rectified flux, tracker decisions and division numerators.
module sfbd_front (
  input  sfbd_pkg::entry_t                  entry_i,
  input  logic [sfbd_pkg::MAG_W-1:0]        mag_i,
  input  logic                              fresh_i,
  output sfbd_pkg::num_t                    num_o
);

  localparam int unsigned MW = sfbd_pkg::MAG_W;

  logic          ge;
  logic [MW-1:0] flux;
  logic [MW-1:0] held;
  logic [MW:0]   avg_sum;
  logic          hit;
  logic          above_slow;

  always_comb begin
    ge   = mag_i >= entry_i.prev_mag;
    held = fresh_i ? mag_i : entry_i.prev_mag;
    if (!fresh_i) begin
      flux = entry_i.prev_flux;
    end else if (ge) begin
      flux = mag_i - entry_i.prev_mag;
    end else begin
      flux = '0;
    end
    avg_sum    = {1'b0, entry_i.avg} + {1'b0, flux};
    hit        = fresh_i && (flux > entry_i.fast);
    above_slow = fresh_i && (flux > entry_i.slow);

    num_o.fresh = fresh_i;
    num_o.hit   = hit;
    num_o.fell  = (flux < entry_i.prev_flux) || (flux == '0);
    num_o.flux  = flux;
    num_o.mag   = held;

    // (5a + 5f) / 10 is exactly the floor of the plain mean.
    num_o.avg_div = fresh_i && !ge;
    num_o.avg_byp = (fresh_i && ge) ? avg_sum[MW:1] : entry_i.avg;
    num_o.avg_num = sfbd_pkg::AVG_N'(entry_i.avg) * sfbd_pkg::AVG_N'(sfbd_pkg::AVG_DECAY_NUM);

    num_o.fast_div = fresh_i && !hit;
    num_o.fast_byp = hit ? flux : entry_i.fast;
    num_o.fast_num = sfbd_pkg::FAST_N'(entry_i.fast) * sfbd_pkg::FAST_N'(sfbd_pkg::FAST_NUM);

    // A zero flux decays by 995/1000, which equals 199/200.
    num_o.slow_div = fresh_i && !above_slow;
    num_o.slow_byp = above_slow ? flux : entry_i.slow;
    if (flux == '0) begin
      num_o.slow_num = sfbd_pkg::SLOW_N'(entry_i.slow) *
                       sfbd_pkg::SLOW_N'(sfbd_pkg::SLOW_ZERO_NUM);
    end else begin
      num_o.slow_num = sfbd_pkg::SLOW_N'(entry_i.slow) *
                       sfbd_pkg::SLOW_N'(sfbd_pkg::SLOW_HOLD_NUM) +
                       sfbd_pkg::SLOW_N'(flux);
    end

    // The peak holds on a zero magnitude and jumps up to a larger one.
    num_o.peak_div = (held != '0) && (held <= entry_i.peak);
    num_o.peak_byp = (held == '0) ? entry_i.peak : held;
    num_o.peak_num = sfbd_pkg::PEAK_N'(entry_i.peak) *
                     sfbd_pkg::PEAK_N'(sfbd_pkg::PEAK_KEEP_NUM) +
                     sfbd_pkg::PEAK_N'(held);
  end

endmodule

[hdl/sfbd_divide.sv]
// Divide stage: constant divisions by reciprocal multiplication and the new band entry.
module sfbd_divide (
  input  sfbd_pkg::num_t   num_i,
  output sfbd_pkg::entry_t entry_o
);

  localparam int unsigned MW  = sfbd_pkg::MAG_W;
  localparam int unsigned APW = 2 * sfbd_pkg::AVG_N + 1;
  localparam int unsigned FPW = 2 * sfbd_pkg::FAST_N + 1;
  localparam int unsigned SPW = 2 * sfbd_pkg::SLOW_N + 1;
  localparam int unsigned PPW = 2 * sfbd_pkg::PEAK_N + 1;

  logic [APW-1:0] avg_prod;
  logic [FPW-1:0] fast_prod;
  logic [SPW-1:0] slow_prod;
  logic [PPW-1:0] peak_prod;

  assign avg_prod  = APW'(num_i.avg_num)  * APW'(sfbd_pkg::AVG_M);
  assign fast_prod = FPW'(num_i.fast_num) * FPW'(sfbd_pkg::FAST_M);
  assign slow_prod = SPW'(num_i.slow_num) * SPW'(sfbd_pkg::SLOW_M);
  assign peak_prod = PPW'(num_i.peak_num) * PPW'(sfbd_pkg::PEAK_M);

  always_comb begin
    entry_o.prev_mag  = num_i.mag;
    entry_o.prev_flux = num_i.flux;
    entry_o.avg  = num_i.avg_div  ? avg_prod[sfbd_pkg::AVG_S +: MW]   : num_i.avg_byp;
    entry_o.fast = num_i.fast_div ? fast_prod[sfbd_pkg::FAST_S +: MW] : num_i.fast_byp;
    entry_o.slow = num_i.slow_div ? slow_prod[sfbd_pkg::SLOW_S +: MW] : num_i.slow_byp;
    entry_o.peak = num_i.peak_div ? peak_prod[sfbd_pkg::PEAK_S +: MW] : num_i.peak_byp;
  end

endmodule

[hdl/spectral_flux_beat_detector.sv]
// Top level of the spectral flux beat detector: band pipeline around the tracker RAM.
//
// One beat on the slave stream carries one spectrum band: band index and magnitude
// in tdata, the fresh flag in tuser, the last-band mark in tlast. Every input beat
// yields exactly one master beat with band, flux, weighted peak, average flux and
// frame total in tdata, beat and flux_fell flags in tuser, and tlast copied.
// The per-band trackers live in one RAM entry per band with a registered read.
// A band is read when it is accepted, its new entry is computed over the read and
// divide stages and written back, and the result passes the decide stage and leaves
// through the output register. Throughput is one band per cycle while the receiver
// takes results and no band directly follows itself. A band that directly follows
// the same band waits for the write-back, then takes the written entry by forwarding.
// Reset clears the pipeline, the frame total and one valid bit per band; a band
// never written reads as all zero, so no clearing pass is needed.
// When the receiver stalls, the stages fill up behind the output register and
// s_axis_tready drops once every stage is occupied, or while a band waits behind itself.
module spectral_flux_beat_detector #(
  parameter int unsigned BAND_COUNT = sfbd_pkg::BAND_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sfbd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // band, magnitude, zero fill
  input  logic [0:0]                          s_axis_tuser,  // fresh
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // band_out, flux, weighted_peak, average_flux, frame_total
  output logic [sfbd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [sfbd_pkg::OUT_USER_W-1:0]     m_axis_tuser,  // beat, flux_fell
  output logic                                m_axis_tlast
);

  localparam int unsigned IDX_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int unsigned BW    = sfbd_pkg::BAND_W;
  localparam int unsigned MW    = sfbd_pkg::MAG_W;
  localparam int unsigned TW    = sfbd_pkg::TOTAL_W;
  localparam int unsigned CW    = 7;

  // Input side.
  logic [BW-1:0]    in_band;
  logic [MW-1:0]    in_mag;
  logic             s_accept;

  // Read stage.
  logic             s1_v_q;
  logic [BW-1:0]    s1_band_q;
  logic [MW-1:0]    s1_mag_q;
  logic             s1_fresh_q;
  logic             s1_last_q;
  logic             fwd_q;
  logic             s1_inr;
  logic [IDX_W-1:0] s1_idx;
  logic             hazard;
  logic             s1_go;
  logic [sfbd_pkg::ENTRY_W-1:0] rd_data;
  sfbd_pkg::entry_t s1_entry;
  sfbd_pkg::num_t   s1_num;

  // Frame total.
  logic [TW-1:0]    acc_q;
  logic [TW:0]      tot_sum;
  logic [TW-1:0]    tot_sat;

  // Divide stage.
  logic             s2_v_q;
  logic [BW-1:0]    s2_band_q;
  logic             s2_inr_q;
  logic             s2_last_q;
  logic [TW-1:0]    s2_total_q;
  sfbd_pkg::num_t   s2_num_q;
  sfbd_pkg::entry_t s2_entry;
  logic [IDX_W-1:0] s2_idx;
  logic             s2_go;
  logic             s2_free;
  logic             wr_en;

  // Last entry written, for a band that waited behind itself.
  sfbd_pkg::entry_t wr_entry_q;
  logic [BAND_COUNT-1:0] band_valid_q;

  // Decide stage.
  logic             s3_v_q;
  logic [BW-1:0]    s3_band_q;
  logic             s3_inr_q;
  logic             s3_last_q;
  logic [TW-1:0]    s3_total_q;
  logic             s3_fresh_q;
  logic             s3_hit_q;
  logic             s3_fell_q;
  logic [MW-1:0]    s3_flux_q;
  logic [MW-1:0]    s3_avg_q;
  logic [MW-1:0]    s3_slow_q;
  logic [MW-1:0]    s3_peak_q;
  logic             s3_go;
  logic             s3_free;
  logic [MW+1:0]    thr_prod;
  logic [MW-1:0]    thr;
  logic             s3_beat;
  logic             s3_fell;

  // Output register.
  logic                          out_v_q;
  logic [sfbd_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [sfbd_pkg::OUT_USER_W-1:0] out_user_q;
  logic                          out_last_q;
  logic                          out_free;

  assign in_band = s_axis_tdata[BW-1:0];
  assign in_mag  = s_axis_tdata[BW +: MW];

  // Handshake chain from the output back to the input.
  assign out_free = !out_v_q || m_axis_tready;
  assign s3_go    = s3_v_q && out_free;
  assign s3_free  = !s3_v_q || s3_go;
  assign s2_go    = s2_v_q && s3_free;
  assign s2_free  = !s2_v_q || s2_go;
  assign s1_inr   = CW'(s1_band_q) < CW'(BAND_COUNT);
  assign s1_idx   = IDX_W'(s1_band_q);
  assign s2_idx   = IDX_W'(s2_band_q);
  // The band in the divide stage has not written its entry yet.
  assign hazard   = s1_v_q && s1_inr && s2_v_q && s2_inr_q && (s2_band_q == s1_band_q);
  assign s1_go    = s1_v_q && s2_free && !hazard;
  assign s_axis_tready = !s1_v_q || s1_go;
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign wr_en    = s2_go && s2_inr_q;

  sfbd_ram #(
    .WIDTH (sfbd_pkg::ENTRY_W),
    .DEPTH (BAND_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s2_idx),
    .wdata_i (s2_entry),
    .re_i    (s_accept),
    .raddr_i (IDX_W'(in_band)),
    .rdata_o (rd_data)
  );

  always_comb begin
    if (fwd_q) begin
      s1_entry = wr_entry_q;
    end else if (s1_inr && band_valid_q[s1_idx]) begin
      s1_entry = sfbd_pkg::entry_t'(rd_data);
    end else begin
      s1_entry = '0;
    end
  end

  sfbd_front u_front (
    .entry_i (s1_entry),
    .mag_i   (s1_mag_q),
    .fresh_i (s1_fresh_q),
    .num_o   (s1_num)
  );

  always_comb begin
    tot_sum = {1'b0, acc_q};
    if (s1_inr && s1_fresh_q) begin
      tot_sum = {1'b0, acc_q} + (TW + 1)'(s1_mag_q);
    end
    tot_sat = tot_sum[TW] ? sfbd_pkg::TOTAL_MAX : tot_sum[TW-1:0];
  end

  sfbd_divide u_divide (
    .num_i   (s2_num_q),
    .entry_o (s2_entry)
  );

  always_comb begin
    thr_prod = (MW + 2)'(s3_slow_q) * (MW + 2)'(sfbd_pkg::THR_NUM);
    thr      = MW'(thr_prod >> sfbd_pkg::THR_SHIFT);
    s3_beat  = s3_inr_q && s3_fresh_q && s3_hit_q && !(s3_flux_q < thr) &&
               !(s3_flux_q < s3_avg_q);
    s3_fell  = s3_inr_q && s3_fresh_q && s3_fell_q && !s3_beat;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      fwd_q        <= 1'b0;
      acc_q        <= '0;
      band_valid_q <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_v_q <= s_axis_tvalid;
      end
      if (s2_free) begin
        s2_v_q <= s1_go;
      end
      if (s3_free) begin
        s3_v_q <= s2_go;
      end
      if (out_free) begin
        out_v_q <= s3_go;
      end
      if (s_accept) begin
        fwd_q <= 1'b0;
      end else if (s2_go && hazard) begin
        fwd_q <= 1'b1;
      end
      if (s1_go) begin
        acc_q <= s1_last_q ? '0 : tot_sat;
      end
      if (wr_en) begin
        band_valid_q[s2_idx] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_band_q  <= in_band;
      s1_mag_q   <= in_mag;
      s1_fresh_q <= s_axis_tuser[0];
      s1_last_q  <= s_axis_tlast;
    end
    if (s1_go) begin
      s2_band_q  <= s1_band_q;
      s2_inr_q   <= s1_inr;
      s2_last_q  <= s1_last_q;
      s2_total_q <= s1_last_q ? tot_sat : '0;
      s2_num_q   <= s1_num;
    end
    if (wr_en) begin
      wr_entry_q <= s2_entry;
    end
    if (s2_go) begin
      s3_band_q  <= s2_band_q;
      s3_inr_q   <= s2_inr_q;
      s3_last_q  <= s2_last_q;
      s3_total_q <= s2_total_q;
      s3_fresh_q <= s2_num_q.fresh;
      s3_hit_q   <= s2_num_q.hit;
      s3_fell_q  <= s2_num_q.fell;
      s3_flux_q  <= s2_entry.prev_flux;
      s3_avg_q   <= s2_entry.avg;
      s3_slow_q  <= s2_entry.slow;
      s3_peak_q  <= s2_entry.peak;
    end
    if (s3_go) begin
      out_data_q <= {s3_total_q,
                     s3_inr_q ? s3_avg_q  : {MW{1'b0}},
                     s3_inr_q ? s3_peak_q : {MW{1'b0}},
                     s3_inr_q ? s3_flux_q : {MW{1'b0}},
                     s3_band_q};
      out_user_q <= {s3_fell, s3_beat};
      out_last_q <= s3_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[hdl/sfbd_checker.sv]
// Port-level checks on the result stream of the beat detector, bound to the top level.
module sfbd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sfbd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [sfbd_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input logic                            m_axis_tlast
);

  // A stalled result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // The frame total is only reported on the last band of a frame.
  a_total_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[71:52] == 20'd0)
    else $error("frame total nonzero on a band that is not last");

  // A beat clears the falling-flux flag.
  a_beat_not_fell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("beat and flux_fell both set");

  // A beat needs flux above the fast maximum, so flux is never zero then.
  a_beat_flux: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[19:4] != 16'd0)
    else $error("beat reported with zero flux");

endmodule

bind spectral_flux_beat_detector sfbd_checker u_sfbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/sv/spectral_flux_beat_detector_checker.sv]
// Checker that predicts every band result of the beat detector and compares it on the output stream.
module spectral_flux_beat_detector_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [sfbd_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // band, magnitude, zero fill
  input  logic [0:0]                        s_axis_tuser,  // fresh
  input  logic                              s_axis_tlast,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // band_out, flux, weighted_peak, average_flux, frame_total
  input  logic [sfbd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic [sfbd_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // beat, flux_fell
  input  logic                              m_axis_tlast,
  output int                                fail_count_o,
  output int                                pending_o
);

  localparam int unsigned NB = sfbd_pkg::BAND_COUNT_DEF;

  typedef struct {
    logic [sfbd_pkg::BAND_W-1:0]  band;
    logic                         beat;
    logic [sfbd_pkg::MAG_W-1:0]   flux;
    logic                         fell;
    logic [sfbd_pkg::MAG_W-1:0]   peak;
    logic [sfbd_pkg::MAG_W-1:0]   avg;
    logic [sfbd_pkg::TOTAL_W-1:0] total;
    logic                         last;
  } band_result_t;

  // Per-band tracker copies, kept at the block's widths.
  logic [sfbd_pkg::MAG_W-1:0]   mag_hist  [NB];
  logic [sfbd_pkg::MAG_W-1:0]   flux_hist [NB];
  logic [sfbd_pkg::MAG_W-1:0]   flux_avg  [NB];
  logic [sfbd_pkg::MAG_W-1:0]   fast_max  [NB];
  logic [sfbd_pkg::MAG_W-1:0]   slow_max  [NB];
  logic [sfbd_pkg::MAG_W-1:0]   mag_peak  [NB];
  int unsigned                  frame_sum;

  band_result_t expected_bands_q[$];

  // The peak holds on a zero magnitude, jumps up to a larger one and otherwise sinks toward it by 1/100.
  function automatic int unsigned peak_toward(input int unsigned peak, input int unsigned mag);
    if (mag == 0) return peak;
    if (mag > peak) return mag;
    return (peak * 99 + mag) / 100;
  endfunction

  function automatic band_result_t predict_band(input logic [sfbd_pkg::BAND_W-1:0] band,
                                                input logic [sfbd_pkg::MAG_W-1:0] mag,
                                                input logic fresh, input logic last);
    band_result_t res;
    int unsigned  m, prev, avg, fast, slow, flux;
    bit           hit;
    res = '{default: '0};
    res.band = band;
    res.last = last;
    m = 32'(mag);
    if (32'(band) < NB) begin
      if (fresh) begin
        prev = 32'(mag_hist[band]);
        avg  = 32'(flux_avg[band]);
        fast = 32'(fast_max[band]);
        slow = 32'(slow_max[band]);
        if (m < prev) begin
          flux = 0;
          avg  = (95 * avg) / 100;
        end else begin
          flux = m - prev;
          avg  = (avg * 5 + 5 * flux) / 10;
        end
        res.fell = (flux < 32'(flux_hist[band])) || (flux == 0);
        // The fast maximum as it stood before this band decides the first condition.
        hit  = flux > fast;
        fast = hit ? flux : (fast * 8) / 10;
        if (flux > slow) begin
          slow = flux;
        end else if (flux == 0) begin
          slow = (slow * 995) / 1000;
        end else begin
          slow = (slow * 999 + flux) / 1000;
        end
        if (flux < (slow * 3) / 8 || flux < avg) hit = 1'b0;
        if (hit) begin
          res.beat = 1'b1;
          res.fell = 1'b0;
        end
        res.flux        = sfbd_pkg::MAG_W'(flux);
        flux_avg[band]  = sfbd_pkg::MAG_W'(avg);
        fast_max[band]  = sfbd_pkg::MAG_W'(fast);
        slow_max[band]  = sfbd_pkg::MAG_W'(slow);
        flux_hist[band] = sfbd_pkg::MAG_W'(flux);
        mag_hist[band]  = mag;
        mag_peak[band]  = sfbd_pkg::MAG_W'(peak_toward(32'(mag_peak[band]), m));
        frame_sum += m;
        if (frame_sum > 32'(sfbd_pkg::TOTAL_MAX)) frame_sum = 32'(sfbd_pkg::TOTAL_MAX);
      end else begin
        res.flux       = flux_hist[band];
        mag_peak[band] = sfbd_pkg::MAG_W'(peak_toward(32'(mag_peak[band]),
                                                      32'(mag_hist[band])));
      end
      res.peak = mag_peak[band];
      res.avg  = flux_avg[band];
    end
    if (last) begin
      res.total = sfbd_pkg::TOTAL_W'(frame_sum);
      frame_sum = 0;
    end
    return res;
  endfunction

  function automatic int field_errors(input string name, input logic [31:0] exp_val,
                                     input logic [31:0] act_val);
    if (exp_val === act_val) return 0;
    $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    band_result_t exp_res;
    int           errs;
    if (!rst_ni) begin
      for (int b = 0; b < NB; b++) begin
        mag_hist[b]  = '0;
        flux_hist[b] = '0;
        flux_avg[b]  = '0;
        fast_max[b]  = '0;
        slow_max[b]  = '0;
        mag_peak[b]  = '0;
      end
      frame_sum = 0;
      expected_bands_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Outputs always trail their inputs, so the result beat is checked before
      // the input beat of the same edge is predicted.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bands_q.size() == 0) begin
          $error("result beat for band %0d arrived with no band outstanding",
                 m_axis_tdata[3:0]);
          fail_count_o++;
        end else begin
          exp_res = expected_bands_q.pop_front();
          errs = 0;
          errs += field_errors("band_out", exp_res.band, m_axis_tdata[3:0]);
          errs += field_errors("flux", exp_res.flux, m_axis_tdata[19:4]);
          errs += field_errors("weighted_peak", exp_res.peak, m_axis_tdata[35:20]);
          errs += field_errors("average_flux", exp_res.avg, m_axis_tdata[51:36]);
          errs += field_errors("frame_total", exp_res.total, m_axis_tdata[71:52]);
          errs += field_errors("beat", exp_res.beat, m_axis_tuser[0]);
          errs += field_errors("flux_fell", exp_res.fell, m_axis_tuser[1]);
          errs += field_errors("last", exp_res.last, m_axis_tlast);
          fail_count_o += errs;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_bands_q.push_back(predict_band(s_axis_tdata[3:0], s_axis_tdata[19:4],
                                                s_axis_tuser[0], s_axis_tlast));
      end
      pending_o = expected_bands_q.size();
    end
  end

endmodule

[tb/sv/spectral_flux_beat_detector_tb.sv]
// Stimulus and verdict for the spectral flux beat detector, with the checker beside it.
module spectral_flux_beat_detector_tb;

  localparam int ITEM_TARGET = 1180;
  localparam int QUIET_ITEMS = 120;
  localparam int CYCLE_LIMIT = 400000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [sfbd_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // band, magnitude, zero fill
  logic [0:0]                      s_axis_tuser;   // fresh
  logic                            s_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [sfbd_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // band_out, flux, weighted_peak,
                                                   // average_flux, frame_total
  logic [sfbd_pkg::OUT_USER_W-1:0] m_axis_tuser;   // beat, flux_fell
  logic                            m_axis_tlast;

  int fail_count;
  int pending;
  int items_sent = 0;
  int cycle_count = 0;
  bit quiet_tail = 1'b0;
  bit calm = 1'b0;

  // Drifting per-band level for frames that look like real spectra.
  int band_level [sfbd_pkg::BAND_COUNT_DEF];

  spectral_flux_beat_detector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  spectral_flux_beat_detector_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: stalls in bursts, except during calm stretches and the tail.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (!quiet_tail && !calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Presents one band beat and returns at the edge that accepts it.
  task automatic put_band(input logic [3:0] band, input logic [15:0] mag,
                          input logic fresh, input logic last);
    if (!quiet_tail && !calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, mag, band};
    s_axis_tuser  <= fresh;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    quiet_tail = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
  endtask

  initial begin
    int          kind, mode, n, lvl;
    logic [15:0] mag;
    bit          fresh;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    for (int b = 0; b < sfbd_pkg::BAND_COUNT_DEF; b++) band_level[b] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero magnitude, full-scale rise, a fall, then ticks with and without a held value.
    put_band(4'd0, 16'h0000, 1'b1, 1'b0);
    put_band(4'd0, 16'hFFFF, 1'b1, 1'b0);
    put_band(4'd0, 16'd1000, 1'b1, 1'b0);
    put_band(4'd0, 16'hFFFF, 1'b0, 1'b0);
    put_band(4'd1, 16'h1234, 1'b0, 1'b0);
    put_band(4'd15, 16'hAAAA, 1'b1, 1'b1);
    // Same band back to back, the second a tick that closes the frame.
    put_band(4'd15, 16'h5555, 1'b1, 1'b0);
    put_band(4'd15, 16'h0000, 1'b0, 1'b1);
    // Small rise followed by a smaller one, so the flux falls.
    put_band(4'd3, 16'd500, 1'b1, 1'b0);
    put_band(4'd3, 16'd600, 1'b1, 1'b0);
    // A frame closed by a band that is not fresh.
    put_band(4'd2, 16'hFFFF, 1'b0, 1'b1);
    // Seventeen full-scale bands, the last one closing the frame, drive the total into saturation.
    for (int i = 0; i < 17; i++) put_band(4'(i), 16'hFFFF, 1'b1, i == 16);

    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 19);
      calm = ($urandom_range(0, 9) == 0);
      if (kind < 14) begin
        mode = $urandom_range(0, 9);
        for (int b = 0; b < sfbd_pkg::BAND_COUNT_DEF; b++) begin
          fresh = ($urandom_range(0, 9) != 0);
          if (mode < 3) begin
            mag = 16'($urandom);
          end else if (mode < 5) begin
            mag = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(4000, 65535)
                                                  : $urandom_range(0, 255));
          end else if (mode < 9) begin
            lvl = band_level[b] + int'($urandom_range(0, 4000)) - 2000;
            if (lvl < 0) lvl = 0;
            if (lvl > 65535) lvl = 65535;
            band_level[b] = lvl;
            // Occasional spikes above the drifting level are what trigger beats.
            if ($urandom_range(0, 9) == 0) lvl = lvl + int'($urandom_range(5000, 30000));
            if (lvl > 65535) lvl = 65535;
            mag = 16'(lvl);
          end else begin
            mag = '0;
          end
          put_band(4'(b), mag, fresh, b == sfbd_pkg::BAND_COUNT_DEF - 1);
        end
      end else if (kind < 17) begin
        for (int b = 0; b < sfbd_pkg::BAND_COUNT_DEF; b++)
          put_band(4'(b), 16'($urandom), 1'b0, b == sfbd_pkg::BAND_COUNT_DEF - 1);
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) put_band(4'($urandom_range(0, 15)), 16'($urandom),
                            1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      end
    end
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
